/* hw/rtl/dlsc_pkg.sv */
// Shared types, constants and LFSR step functions for the dual LFSR stream cipher.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package dlsc_pkg;

    localparam int unsigned DataWidth  = 8;
    localparam int unsigned KeyWidth   = 40;
    localparam int unsigned ShortWidth = 17;
    localparam int unsigned LongWidth  = 25;
    localparam int unsigned ShortSeedWidth = 16;
    localparam int unsigned LongSeedWidth  = 24;

    typedef logic [DataWidth-1:0]  byte_t;
    typedef logic [KeyWidth-1:0]   key_t;
    typedef logic [ShortWidth-1:0] short_lfsr_t;
    typedef logic [LongWidth-1:0]  long_lfsr_t;

    // Control from the input stage to the keystream generator.
    typedef struct packed {
        logic advance;
        logic start;
    } gen_ctrl_t;

    typedef struct packed {
        short_lfsr_t state;
        byte_t       out_byte;
    } short_step_t;

    typedef struct packed {
        long_lfsr_t state;
        byte_t      out_byte;
    } long_step_t;

    // Eight shifts of the short register, taps at bits 16 and 2, first bit lands in the MSB.
    function automatic short_step_t short_step8(input short_lfsr_t seed);
        short_step_t res;
        short_lfsr_t s;
        byte_t       ob;
        logic        fb;
        s  = seed;
        ob = '0;
        for (int i = 0; i < DataWidth; i++)
        begin
            fb = s[16] ^ s[2];
            ob = {ob[DataWidth-2:0], fb};
            s  = {fb, s[ShortWidth-1:1]};
        end
        res.state    = s;
        res.out_byte = ob;
        return res;
    endfunction

    // Eight shifts of the long register, taps at bits 24, 7, 5 and 1.
    function automatic long_step_t long_step8(input long_lfsr_t seed);
        long_step_t res;
        long_lfsr_t s;
        byte_t      ob;
        logic       fb;
        s  = seed;
        ob = '0;
        for (int i = 0; i < DataWidth; i++)
        begin
            fb = s[24] ^ s[7] ^ s[5] ^ s[1];
            ob = {ob[DataWidth-2:0], fb};
            s  = {fb, s[LongWidth-1:1]};
        end
        res.state    = s;
        res.out_byte = ob;
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/dlsc_if.sv */
// Valid/ready channel interfaces for data in, data out and key writes.
// Depends on dlsc_pkg for payload types.
`default_nettype none

interface dlsc_in_if
    import dlsc_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t data_in;
    logic  start_of_message;

    modport source (output valid, output data_in, output start_of_message, input ready);
    modport sink   (input valid, input data_in, input start_of_message, output ready);
endinterface

interface dlsc_out_if
    import dlsc_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

interface dlsc_cfg_if
    import dlsc_pkg::*;
();
    logic valid;
    logic ready;
    key_t cipher_key;

    modport source (output valid, output cipher_key, input ready);
    modport sink   (input valid, input cipher_key, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dual_lfsr_add_stream_cipher_core.sv */
// Top level of the dual LFSR stream cipher: key register, input stage,
// keystream generator and result register. Depends on dlsc_pkg, dlsc_if,
// dlsc_in_stage and dlsc_keygen.
//
//   channel | modport | payload                          | moves
//   --------+---------+----------------------------------+---------------------
//   in_ch   | sink    | data_in[7:0], start_of_message   | one item per byte
//   out_ch  | source  | data_out[7:0]                    | one item per input
//   cfg_ch  | sink    | cipher_key[39:0]                 | key write, always ready
//
// One item per cycle sustained while the output is ready; the result passes through
// the input register and then the result register.
// Both LFSRs step eight places in combinational XOR logic, then an 8-bit add.
// Reset clears the LFSRs, carry and key to zero; no clearing pass.
// An output stall holds the result register; the input stage takes one more
// item, then input ready drops until the result is taken.
`default_nettype none

module dual_lfsr_add_stream_cipher_core
    import dlsc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    dlsc_in_if.sink    in_ch,
    dlsc_out_if.source out_ch,
    dlsc_cfg_if.sink   cfg_ch
);

    key_t      key_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    byte_t     out_data_reg;
    logic      take;
    logic      held_valid;
    byte_t     held_data;
    gen_ctrl_t ctrl;
    byte_t     key_byte;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            key_reg <= cfg_ch.cipher_key;
        end
    end

    // Advance the held item when the result register is free or emptying.
    assign take = !out_valid_reg || out_ch.ready;

    dlsc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .take       (take),
        .held_valid (held_valid),
        .held_data  (held_data),
        .ctrl       (ctrl)
    );

    dlsc_keygen u_keygen (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cipher_key (key_reg),
        .key_byte   (key_byte)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = held_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            out_data_reg <= held_data ^ key_byte;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.data_out = out_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/dlsc_in_stage.sv */
// Input register stage: captures one item and hands it to the keystream logic.
// Depends on dlsc_pkg and dlsc_in_if.
`default_nettype none

module dlsc_in_stage
    import dlsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    dlsc_in_if.sink   in_ch,
    input  wire logic take,
    output logic      held_valid,
    output byte_t     held_data,
    output gen_ctrl_t ctrl
);

    logic  valid_reg;
    logic  valid_next;
    byte_t data_reg;
    logic  start_reg;
    logic  load;

    // Accept whenever the stage is empty or the held item leaves in the same cycle.
    assign in_ch.ready = !valid_reg || take;
    assign load        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= in_ch.data_in;
            start_reg <= in_ch.start_of_message;
        end
    end

    assign held_valid   = valid_reg;
    assign held_data    = data_reg;
    assign ctrl.advance = take && valid_reg;
    assign ctrl.start   = start_reg;

endmodule

`default_nettype wire

/* hw/rtl/dlsc_keygen.sv */
// Keystream generator: both LFSRs and the running carry, one byte per advance.
// Depends on dlsc_pkg.
`default_nettype none

module dlsc_keygen
    import dlsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire gen_ctrl_t ctrl,
    input  wire key_t      cipher_key,
    output byte_t          key_byte
);

    short_lfsr_t short_reg;
    long_lfsr_t  long_reg;
    logic        carry_reg;

    short_lfsr_t short_seed;
    long_lfsr_t  long_seed;
    logic        carry_in;
    short_step_t short_res;
    long_step_t  long_res;
    logic [DataWidth:0] sum;

    // On a start, reseed from the key with a forced one in bit 0 and drop the carry.
    always_comb
    begin
        if (ctrl.start)
        begin
            short_seed = {cipher_key[KeyWidth-1 -: ShortSeedWidth], 1'b1};
            long_seed  = {cipher_key[LongSeedWidth-1:0], 1'b1};
            carry_in   = 1'b0;
        end
        else
        begin
            short_seed = short_reg;
            long_seed  = long_reg;
            carry_in   = carry_reg;
        end
        short_res = short_step8(short_seed);
        long_res  = long_step8(long_seed);
        sum = {1'b0, short_res.out_byte} + {1'b0, long_res.out_byte}
            + {{DataWidth{1'b0}}, carry_in};
    end

    assign key_byte = sum[DataWidth-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= '0;
            long_reg  <= '0;
            carry_reg <= 1'b0;
        end
        else if (ctrl.advance)
        begin
            short_reg <= short_res.state;
            long_reg  <= long_res.state;
            carry_reg <= sum[DataWidth];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dlsc_checker.sv */
// Port-level checks for dual_lfsr_add_stream_cipher_core, attached by bind.
// Depends on dlsc_pkg for the byte type.
`default_nettype none

module dlsc_checker
    import dlsc_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  in_valid,
    input wire logic  in_ready,
    input wire logic  out_valid,
    input wire logic  out_ready,
    input wire byte_t data_out,
    input wire logic  cfg_ready
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_out))
        else $error("result changed or dropped while stalled");

    // With the result register empty the block must take input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result register");

    // An accepted item moves into an empty result register on the next edge.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 !out_valid |=> out_valid)
        else $error("accepted item did not reach the output");

    // Key writes are never stalled.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("key write port not ready");

endmodule

bind dual_lfsr_add_stream_cipher_core dlsc_checker u_dlsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .data_out  (out_ch.data_out),
    .cfg_ready (cfg_ch.ready)
);

`default_nettype wire

/* tb/sv/dual_lfsr_add_stream_cipher_core_tb.sv */
// Testbench for dual_lfsr_add_stream_cipher_core: drives key writes and data bytes,
// predicts each output byte from the two LFSRs and the carrying adder, and checks it.
// Depends on dlsc_pkg, the channel interfaces in dlsc_if and the core itself.
`default_nettype none

module dual_lfsr_add_stream_cipher_core_tb;
    import dlsc_pkg::*;

    localparam int unsigned CycleLimit  = 400_000;
    localparam int unsigned RandomItems = 1750;
    localparam int unsigned StallPct    = 13;
    localparam int unsigned MaxPrinted  = 40;

    // Tracks the cipher state and the output bytes still owed by the core.
    class cipher_byte_tracker;
        key_t        key_q;
        short_lfsr_t short_q;
        long_lfsr_t  long_q;
        bit          carry_q;
        byte_t       owed_bytes[$];
        int unsigned mismatches;
        int unsigned accepted;

        function new();
            key_q      = '0;
            short_q    = '0;
            long_q     = '0;
            carry_q    = 1'b0;
            mismatches = 0;
            accepted   = 0;
        endfunction

        function void take_key(key_t k);
            key_q = k;
        endfunction

        function byte_t short_keystream();
            byte_t ks;
            logic  fb;
            ks = '0;
            for (int i = 0; i < 8; i++)
            begin
                fb      = short_q[16] ^ short_q[2];
                ks      = {ks[6:0], fb};
                short_q = {fb, short_q[ShortWidth-1:1]};
            end
            return ks;
        endfunction

        function byte_t long_keystream();
            byte_t ks;
            logic  fb;
            ks = '0;
            for (int i = 0; i < 8; i++)
            begin
                fb     = long_q[24] ^ long_q[7] ^ long_q[5] ^ long_q[1];
                ks     = {ks[6:0], fb};
                long_q = {fb, long_q[LongWidth-1:1]};
            end
            return ks;
        endfunction

        // Reload on start, then add both keystream bytes with the running carry.
        function void note_input(byte_t din, bit som);
            byte_t      ks_short;
            byte_t      ks_long;
            logic [8:0] sum;
            if (som)
            begin
                short_q = {key_q[KeyWidth-1 -: ShortSeedWidth], 1'b1};
                long_q  = {key_q[LongSeedWidth-1:0], 1'b1};
                carry_q = 1'b0;
            end
            ks_short = short_keystream();
            ks_long  = long_keystream();
            sum      = {1'b0, ks_short} + {1'b0, ks_long} + {8'd0, carry_q};
            carry_q  = sum[8];
            owed_bytes.push_back(sum[7:0] ^ din);
            accepted++;
        endfunction

        task report_mismatch(string what);
            if (mismatches < MaxPrinted)
                $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(byte_t dout);
            byte_t want;
            if (owed_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected data_out %02h", dout));
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (dout !== want)
                    report_mismatch($sformatf("data_out %02h, want %02h", dout, want));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int unsigned cycles;

    cipher_byte_tracker tracker;

    dlsc_in_if  in_ch();
    dlsc_out_if out_ch();
    dlsc_cfg_if cfg_ch();

    dual_lfsr_add_stream_cipher_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    always #6 clk = ~clk;

    // Check results and stall the output side at random.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_result(out_ch.data_out);
        out_ch.ready <= steady || ($urandom_range(99) >= StallPct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CycleLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic byte_t rand_byte();
        return byte_t'($urandom_range(255));
    endfunction

    task automatic send_item(input byte_t din, input bit som);
        if (!steady && $urandom_range(99) < StallPct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.data_in          <= din;
        in_ch.start_of_message <= som;
        do @(posedge clk); while (!in_ch.ready);
        tracker.note_input(din, som);
    endtask

    // Drop valid and hold until every owed byte has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (tracker.owed_bytes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_key(input key_t k);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.cipher_key <= k;
        do @(posedge clk); while (!cfg_ch.ready);
        tracker.take_key(k);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_message(input int unsigned len);
        send_item(rand_byte(), 1'b1);
        repeat (len) send_item(rand_byte(), 1'b0);
    endtask

    function automatic key_t pick_key();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return {{ShortSeedWidth{1'b1}}, {LongSeedWidth{1'b0}}};
            3: return {{ShortSeedWidth{1'b0}}, {LongSeedWidth{1'b1}}};
            default: return key_t'({$urandom(), $urandom()});
        endcase
    endfunction

    initial
    begin
        tracker = new();
        clk     = 1'b0;
        rst_n   = 1'b0;
        steady  = 1'b0;
        cycles  = 0;
        in_ch.valid            = 1'b0;
        in_ch.data_in          = '0;
        in_ch.start_of_message = 1'b0;
        out_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.cipher_key      = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No start since reset: keystream is zero.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h5A, 1'b0);
        // Start with the reset key.
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        drain();

        // New key mid-message: old state runs on until the next start.
        write_key('1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h7F, 1'b0);
        drain();

        write_key('0);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hAA, 1'b0);
        send_item(8'h55, 1'b1);
        drain();

        write_key({{ShortSeedWidth{1'b1}}, {LongSeedWidth{1'b0}}});
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hC3, 1'b0);
        drain();

        // Random phases: a key, a tail of the old message, then messages and noise.
        steady = 1'b1;
        while (tracker.accepted < RandomItems)
        begin
            write_key(pick_key());
            repeat ($urandom_range(0, 3)) send_item(rand_byte(), 1'b0);
            repeat ($urandom_range(3, 8))
            begin
                if ($urandom_range(9) == 0)
                begin
                    repeat ($urandom_range(1, 12))
                        send_item(rand_byte(), 1'($urandom_range(1)));
                end
                else
                begin
                    send_message($urandom_range(1, 40));
                end
            end
            drain();
            steady = ($urandom_range(5) == 0);
        end

        steady = 1'b0;
        drain();
        repeat (10) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
